@@ design/rxnfa_pkg.sv @@
package rxnfa_pkg;

  localparam int MAX_STATES  = 255;
  localparam int STACK_DEPTH = 64;
  localparam int ID_LIMIT    = (MAX_STATES < 255) ? MAX_STATES : 255;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int NID_W       = $clog2(ID_LIMIT + 2);
  localparam int MAX_RECS    = 5;
  localparam int RCNT_W      = $clog2(MAX_RECS + 1);

  localparam logic [7:0] SYM_CAT   = 8'h2E;
  localparam logic [7:0] SYM_ALT   = 8'h7C;
  localparam logic [7:0] SYM_STAR  = 8'h2A;
  localparam logic [7:0] SYM_OPT   = 8'h3F;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] EPS_LABEL = 8'h24;
  localparam logic [7:0] NO_LABEL  = 8'h00;
  localparam logic [7:0] NO_ID     = 8'h00;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNDER = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;
  localparam logic [1:0] ERR_IDS   = 2'd3;

  typedef struct packed {
    logic [7:0] start;
    logic [7:0] acc;
  } frag_t;

  typedef struct packed {
    logic [7:0] state_id;
    logic [7:0] transition;
    logic [7:0] next_first;
    logic [7:0] next_second;
    logic       accepting;
    logic       final_result;
    logic [1:0] error_code;
  } rec_t;

  typedef struct packed {
    frag_t             top0;
    frag_t             top1;
    logic [CNT_W-1:0]  count;
    logic [NID_W-1:0]  next_id;
  } stk_t;

  typedef struct packed {
    rec_t [MAX_RECS-1:0] recs;
    logic [RCNT_W-1:0]   nrec;
    stk_t                st;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    frag_t               wr_data;
  } step_t;

  function automatic rec_t mk_rec(logic [7:0] id, logic [7:0] tr, logic [7:0] n1,
                                  logic [7:0] n2, logic acc, logic fin,
                                  logic [1:0] err);
    rec_t r;
    r.state_id     = id;
    r.transition   = tr;
    r.next_first   = n1;
    r.next_second  = n2;
    r.accepting    = acc;
    r.final_result = fin;
    r.error_code   = err;
    return r;
  endfunction

endpackage

@@ design/rxnfa_sym_if.sv @@
interface rxnfa_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last_symbol;

  modport source (output valid, symbol, last_symbol, input ready);
  modport sink (input valid, symbol, last_symbol, output ready);
endinterface

@@ design/rxnfa_rec_if.sv @@
interface rxnfa_rec_if;
  logic       valid;
  logic       ready;
  logic [7:0] state_id;
  logic [7:0] transition;
  logic [7:0] next_first;
  logic [7:0] next_second;
  logic       accepting;
  logic       final_result;
  logic [1:0] error_code;
  logic       run_end;

  modport source (output valid, state_id, transition, next_first, next_second,
                  accepting, final_result, error_code, run_end, input ready);
  modport sink (input valid, state_id, transition, next_first, next_second,
                accepting, final_result, error_code, run_end, output ready);
endinterface

@@ design/rxnfa_step.sv @@
module rxnfa_step (
  input  logic [7:0]         symbol,
  input  logic               last_symbol,
  input  rxnfa_pkg::stk_t    st,
  input  rxnfa_pkg::frag_t   below,
  output rxnfa_pkg::step_t   res
);
  import rxnfa_pkg::*;

  localparam logic [2:0] OP_LIT  = 3'd0;
  localparam logic [2:0] OP_CAT  = 3'd1;
  localparam logic [2:0] OP_ALT  = 3'd2;
  localparam logic [2:0] OP_STAR = 3'd3;
  localparam logic [2:0] OP_OPT  = 3'd4;
  localparam logic [2:0] OP_PLUS = 3'd5;

  logic [2:0]       op;
  logic [1:0]       pops;
  logic [1:0]       ids;
  logic [1:0]       err;
  logic [NID_W:0]   id_sum;
  logic [7:0]       ns;
  logic [7:0]       na;

  always_comb begin
    unique case (symbol)
      SYM_CAT:  op = OP_CAT;
      SYM_ALT:  op = OP_ALT;
      SYM_STAR: op = OP_STAR;
      SYM_OPT:  op = OP_OPT;
      SYM_PLUS: op = OP_PLUS;
      default:  op = OP_LIT;
    endcase
  end

  always_comb begin
    unique case (op)
      OP_CAT:  begin pops = 2'd2; ids = 2'd0; end
      OP_ALT:  begin pops = 2'd2; ids = 2'd2; end
      OP_STAR: begin pops = 2'd1; ids = 2'd2; end
      OP_OPT:  begin pops = 2'd1; ids = 2'd2; end
      OP_PLUS: begin pops = 2'd1; ids = 2'd1; end
      default: begin pops = 2'd0; ids = 2'd2; end
    endcase
  end

  assign id_sum = {1'b0, st.next_id} + (NID_W+1)'(ids);
  assign ns     = 8'(st.next_id);
  assign na     = ns + 8'd1;

  always_comb begin
    priority if (st.count < CNT_W'(pops)) begin
      err = ERR_UNDER;
    end else if (pops == 2'd0 && st.count >= CNT_W'(STACK_DEPTH)) begin
      err = ERR_OVER;
    end else if (id_sum > (NID_W+1)'(ID_LIMIT + 1)) begin
      err = ERR_IDS;
    end else begin
      err = ERR_NONE;
    end
  end

  always_comb begin
    res         = '0;
    res.st      = st;
    res.nrec    = RCNT_W'(1);
    res.wr_en   = 1'b0;
    res.wr_addr = ADDR_W'(st.count - CNT_W'(2));
    res.wr_data = st.top1;
    if (err != ERR_NONE) begin
      res.recs[0] = mk_rec(NO_ID, NO_LABEL, NO_ID, NO_ID, 1'b0, 1'b0, err);
      if (last_symbol) begin
        res.st.count   = '0;
        res.st.next_id = NID_W'(1);
      end
    end else begin
      res.st.next_id = id_sum[NID_W-1:0];
      unique case (op)
        OP_CAT: begin
          res.recs[0]     = mk_rec(st.top1.acc, EPS_LABEL, st.top0.start, NO_ID,
                                   1'b0, 1'b0, ERR_NONE);
          res.st.top0     = '{start: st.top1.start, acc: st.top0.acc};
          res.st.top1     = below;
          res.st.count    = st.count - CNT_W'(1);
        end
        OP_ALT: begin
          res.recs[0]     = mk_rec(ns, EPS_LABEL, st.top1.start, st.top0.start,
                                   1'b0, 1'b0, ERR_NONE);
          res.recs[1]     = mk_rec(na, NO_LABEL, NO_ID, NO_ID, 1'b1, 1'b0, ERR_NONE);
          res.recs[2]     = mk_rec(st.top1.acc, EPS_LABEL, na, NO_ID, 1'b0, 1'b0, ERR_NONE);
          res.recs[3]     = mk_rec(st.top0.acc, EPS_LABEL, na, NO_ID, 1'b0, 1'b0, ERR_NONE);
          res.nrec        = RCNT_W'(4);
          res.st.top0     = '{start: ns, acc: na};
          res.st.top1     = below;
          res.st.count    = st.count - CNT_W'(1);
        end
        OP_STAR, OP_OPT: begin
          res.recs[0]     = mk_rec(ns, EPS_LABEL, st.top0.start, na, 1'b0, 1'b0, ERR_NONE);
          res.recs[1]     = mk_rec(na, NO_LABEL, NO_ID, NO_ID, 1'b1, 1'b0, ERR_NONE);
          res.recs[2]     = mk_rec(st.top0.acc, EPS_LABEL, na,
                                   (op == OP_STAR) ? st.top0.start : NO_ID,
                                   1'b0, 1'b0, ERR_NONE);
          res.nrec        = RCNT_W'(3);
          res.st.top0     = '{start: ns, acc: na};
        end
        OP_PLUS: begin
          res.recs[0]     = mk_rec(ns, NO_LABEL, NO_ID, NO_ID, 1'b1, 1'b0, ERR_NONE);
          res.recs[1]     = mk_rec(st.top0.acc, EPS_LABEL, ns, st.top0.start,
                                   1'b0, 1'b0, ERR_NONE);
          res.nrec        = RCNT_W'(2);
          res.st.top0     = '{start: st.top0.start, acc: ns};
        end
        default: begin
          res.recs[0]     = mk_rec(ns, symbol, na, NO_ID, 1'b0, 1'b0, ERR_NONE);
          res.recs[1]     = mk_rec(na, NO_LABEL, NO_ID, NO_ID, 1'b1, 1'b0, ERR_NONE);
          res.nrec        = RCNT_W'(2);
          res.st.top0     = '{start: ns, acc: na};
          res.st.top1     = st.top0;
          res.st.count    = st.count + CNT_W'(1);
          res.wr_en       = (st.count >= CNT_W'(2));
        end
      endcase
      if (last_symbol) begin
        for (int i = 0; i < MAX_RECS; i++) begin
          if (RCNT_W'(i) == res.nrec) begin
            res.recs[i] = mk_rec(res.st.top0.start, NO_LABEL, NO_ID, NO_ID,
                                 1'b0, 1'b1, ERR_NONE);
          end
        end
        res.nrec       = res.nrec + RCNT_W'(1);
        res.st.count   = '0;
        res.st.next_id = NID_W'(1);
      end
    end
  end

endmodule

@@ design/rxnfa_outbuf.sv @@
module rxnfa_outbuf (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        load,
  input  rxnfa_pkg::rec_t [rxnfa_pkg::MAX_RECS-1:0]   recs,
  input  logic [rxnfa_pkg::RCNT_W-1:0]                nrec,
  output logic                                        free,
  rxnfa_rec_if.source                                 rec
);
  import rxnfa_pkg::*;

  logic                 busy;
  logic [RCNT_W-1:0]    idx;
  logic [RCNT_W-1:0]    cnt;
  rec_t [MAX_RECS-1:0]  slots;
  logic                 at_end;
  rec_t                 cur;

  assign at_end = (idx == cnt - RCNT_W'(1));
  assign free   = !busy || (rec.ready && at_end);
  assign cur    = slots[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && rec.ready) begin
      if (at_end) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + RCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= recs;
      cnt   <= nrec;
    end
  end

  assign rec.valid        = busy;
  assign rec.state_id     = cur.state_id;
  assign rec.transition   = cur.transition;
  assign rec.next_first   = cur.next_first;
  assign rec.next_second  = cur.next_second;
  assign rec.accepting    = cur.accepting;
  assign rec.final_result = cur.final_result;
  assign rec.error_code   = cur.error_code;
  assign rec.run_end      = at_end;

endmodule

@@ design/postfix_regex_to_nfa_builder_top.sv @@
// channel | dir | payload                                        | handshake
// sym     | in  | symbol[7:0], last_symbol                        | valid/ready
// rec     | out | state_id, transition, next_first, next_second,   | valid/ready
//         |     | accepting, final_result, error_code, run_end     |
//
// One symbol yields 1 to 5 records (literal 2, '.' 1, '|' 4, '*'/'?' 3,
// '+' 2, +1 on the last symbol, error 1), which hold the record buffer until
// they leave one by one through the single record output port.
// A symbol waits in the input register while the buffer drains; the next one
// is taken in the cycle the last record of the previous one leaves.
// Reset (rst, synchronous) empties the stack and restarts ids at 1; the
// fragment memory is not cleared.
module postfix_regex_to_nfa_builder_top (
  input logic         clk,
  input logic         rst,
  rxnfa_sym_if.sink   sym,
  rxnfa_rec_if.source rec
);
  import rxnfa_pkg::*;

  logic               in_valid;
  logic [7:0]         in_symbol;
  logic               in_last;
  logic               free;
  logic               load;
  stk_t               st;
  stk_t               st_next;
  frag_t              below;
  step_t              res;
  logic [ADDR_W-1:0]  rd_addr;
  frag_t              mem [STACK_DEPTH];

  assign sym.ready = !in_valid || free;
  assign load      = in_valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sym.valid && sym.ready) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sym.valid && sym.ready) begin
      in_symbol <= sym.symbol;
      in_last   <= sym.last_symbol;
    end
  end

  rxnfa_step u_step (
    .symbol      (in_symbol),
    .last_symbol (in_last),
    .st          (st),
    .below       (below),
    .res         (res)
  );

  assign st_next = load ? res.st : st;
  assign rd_addr = ADDR_W'(st_next.count - CNT_W'(3));

  always_ff @(posedge clk) begin
    if (rst) begin
      st.count   <= '0;
      st.next_id <= NID_W'(1);
    end else if (load) begin
      st <= res.st;
    end
  end

  // third fragment from the top, kept ready for the next pop
  always_ff @(posedge clk) begin
    if (load && res.wr_en) begin
      mem[res.wr_addr] <= res.wr_data;
    end
    if (load && res.wr_en && res.wr_addr == rd_addr) begin
      below <= res.wr_data;
    end else begin
      below <= mem[rd_addr];
    end
  end

  rxnfa_outbuf u_outbuf (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .recs (res.recs),
    .nrec (res.nrec),
    .free (free),
    .rec  (rec)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    st.count <= CNT_W'(STACK_DEPTH))
    else $error("fragment count out of range");

  a_id_range: assert property (@(posedge clk) disable iff (rst)
    st.next_id != '0 && st.next_id <= NID_W'(ID_LIMIT + 1))
    else $error("state id counter out of range");

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    load && in_last |=> st.count == '0 && st.next_id == NID_W'(1))
    else $error("state not reset after last symbol");

  a_load_fills: assert property (@(posedge clk) disable iff (rst)
    load |=> rec.valid)
    else $error("loaded transaction produced no record");

endmodule
